// ----- sv/sli_pkg.sv -----
// shared types and constants for the sigmoid table interpolator
package sli_pkg;

  localparam int unsigned LUT_ENTRIES_DEF    = 256;
  localparam int unsigned FRACTION_SHIFT_DEF = 22;
  localparam int unsigned OUT_FRACTION_DEF   = 15;

  localparam int unsigned NET_W    = 32;
  localparam int unsigned ACT_W    = 15;
  localparam int unsigned TIDX_W   = 8;
  localparam int unsigned LIM_W    = 31;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [LIM_W-1:0] MAX_INPUT_RST = 31'd1073741824;
  localparam logic [LIM_W-1:0] MIN_INPUT_RST = 31'h4000_0000;
  localparam logic [ACT_W-1:0] ACTIV_MAX_RST = 15'h7fff;
  localparam logic [ACT_W-1:0] ACTIV_MIN_RST = 15'h0000;
  localparam logic [ACT_W-1:0] ACT_FULL      = 15'h7fff;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROUND_INPUT = 3'd0,
    CFG_MAX_INPUT   = 3'd1,
    CFG_MIN_INPUT   = 3'd2,
    CFG_ACTIV_MAX   = 3'd3,
    CFG_ACTIV_MIN   = 3'd4
  } sli_cfg_idx_e;

  typedef enum logic {
    REQ_WRITE = 1'b0,
    REQ_EVAL  = 1'b1
  } sli_req_e;

  typedef struct packed {
    logic sat_max;
    logic sat_min;
    logic neg;
    logic beyond;
  } sli_flags_t;

endpackage

// ----- sv/sli_table.sv -----
// sample table: two synchronous copies so both neighbors are read in the same cycle
module sli_table #(
  parameter int unsigned DEPTH = sli_pkg::LUT_ENTRIES_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [AW-1:0]            waddr_i,
  input  logic [sli_pkg::ACT_W-1:0] wdata_i,
  input  logic                     re_i,
  input  logic [AW-1:0]            raddr0_i,
  input  logic [AW-1:0]            raddr1_i,
  output logic [sli_pkg::ACT_W-1:0] rdata0_o,
  output logic [sli_pkg::ACT_W-1:0] rdata1_o
);
  import sli_pkg::*;

  logic [ACT_W-1:0] mem0 [DEPTH];
  logic [ACT_W-1:0] mem1 [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem0[waddr_i] <= wdata_i;
      mem1[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata0_o <= mem0[raddr0_i];
      rdata1_o <= mem1[raddr1_i];
    end
  end

endmodule

// ----- sv/sigmoid_lut_interpolator_top.sv -----
// sigmoid evaluator: loadable sample table, linear interpolation, 4-stage pipeline
// an accepted beat goes through stage 1 (request), 2 (samples), 3 (product) and 4 (output)
// throughput: one beat per cycle unless stalled; both neighbor samples come from two table copies
// table writes take the same pipeline slot and give no result
// reset clears pipeline valids and config registers; table contents are undefined until written
module sigmoid_lut_interpolator_top #(
  parameter int unsigned LUT_ENTRIES    = sli_pkg::LUT_ENTRIES_DEF,
  parameter int unsigned FRACTION_SHIFT = sli_pkg::FRACTION_SHIFT_DEF,
  parameter int unsigned OUT_FRACTION   = sli_pkg::OUT_FRACTION_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         req_type_i,
  input  logic [sli_pkg::TIDX_W-1:0]   table_index_i,
  input  logic [sli_pkg::ACT_W-1:0]    table_value_i,
  input  logic signed [sli_pkg::NET_W-1:0] net_input_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [sli_pkg::ACT_W-1:0]    activation_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [sli_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [sli_pkg::LIM_W-1:0]    cfg_data_i
);
  import sli_pkg::*;

  localparam int unsigned AW = $clog2(LUT_ENTRIES);
  localparam int unsigned IW = (AW > TIDX_W) ? AW : TIDX_W;
  localparam int unsigned XW = NET_W + 1;
  localparam int unsigned PW = ACT_W + 1 + FRACTION_SHIFT + 1;
  localparam int unsigned FW = 18;
  localparam logic signed [XW-1:0] HALF_X = XW'(1) << (FRACTION_SHIFT - 1);
  localparam logic signed [PW:0]   HALF_P = (PW + 1)'(1) << (FRACTION_SHIFT - 1);
  localparam logic signed [FW-1:0] ONE_F  = FW'(1) << OUT_FRACTION;

  // configuration registers
  logic                    round_q;
  logic [LIM_W-1:0]        max_input_q;
  logic [LIM_W-1:0]        min_input_q;
  logic [ACT_W-1:0]        activ_max_q;
  logic [ACT_W-1:0]        activ_min_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      round_q     <= 1'b0;
      max_input_q <= MAX_INPUT_RST;
      min_input_q <= MIN_INPUT_RST;
      activ_max_q <= ACTIV_MAX_RST;
      activ_min_q <= ACTIV_MIN_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_ROUND_INPUT: round_q     <= cfg_data_i[0];
        CFG_MAX_INPUT:   max_input_q <= cfg_data_i;
        CFG_MIN_INPUT:   min_input_q <= cfg_data_i;
        CFG_ACTIV_MAX:   activ_max_q <= cfg_data_i[ACT_W-1:0];
        CFG_ACTIV_MIN:   activ_min_q <= cfg_data_i[ACT_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline valids and backpressure
  logic v1_q, v2_q, v3_q, v4_q;
  logic ready1, ready2, ready3, ready4;

  assign ready4     = !v4_q || !out_stall_i;
  assign ready3     = !v3_q || ready4;
  assign ready2     = !v2_q || ready3;
  assign ready1     = !v1_q || ready2;
  assign in_stall_o = !ready1;

  // stage 1: registered request
  logic                    req1_q;
  logic [TIDX_W-1:0]       tidx1_q;
  logic [ACT_W-1:0]        tval1_q;
  logic signed [NET_W-1:0] net1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (ready1) begin
      v1_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && ready1) begin
      req1_q  <= req_type_i;
      tidx1_q <= table_index_i;
      tval1_q <= table_value_i;
      net1_q  <= net_input_i;
    end
  end

  // stage 1 logic: round, limit compare, magnitude split
  logic signed [XW-1:0] x_r;
  logic [XW-1:0]        mag;
  logic [XW-1:0]        idx_full;
  logic [AW-1:0]        addr0, addr1;
  logic [FRACTION_SHIFT-1:0] rem1;
  logic                 last1;
  sli_flags_t           flags1;
  logic                 is_eval1, is_write1, wr_in_range;
  logic [IW-1:0]        widx;

  always_comb begin
    x_r = XW'(net1_q) + (round_q ? HALF_X : '0);
    flags1.sat_max = x_r >= $signed({2'b00, max_input_q});
    flags1.sat_min = x_r <= $signed({{2{min_input_q[LIM_W-1]}}, min_input_q});
    flags1.neg     = x_r[XW-1];
    mag            = flags1.neg ? XW'(-x_r) : XW'(x_r);
    idx_full       = mag >> FRACTION_SHIFT;
    flags1.beyond  = idx_full >= XW'(LUT_ENTRIES);
    last1          = idx_full == XW'(LUT_ENTRIES - 1);
    addr0          = idx_full[AW-1:0];
    addr1          = addr0 + AW'(1);
    rem1           = mag[FRACTION_SHIFT-1:0];
  end

  assign is_eval1    = req1_q == REQ_EVAL;
  assign is_write1   = req1_q == REQ_WRITE;
  assign wr_in_range = 32'(tidx1_q) < 32'(LUT_ENTRIES);
  assign widx        = IW'(tidx1_q);

  logic [ACT_W-1:0] y0_rd, y1_rd;

  sli_table #(
    .DEPTH(LUT_ENTRIES),
    .AW   (AW)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (v1_q && ready2 && is_write1 && wr_in_range),
    .waddr_i (widx[AW-1:0]),
    .wdata_i (tval1_q),
    .re_i    (v1_q && ready2 && is_eval1),
    .raddr0_i(addr0),
    .raddr1_i(addr1),
    .rdata0_o(y0_rd),
    .rdata1_o(y1_rd)
  );

  // stage 2: samples arrive, form difference and product
  sli_flags_t                flags2_q;
  logic                      last2_q;
  logic [FRACTION_SHIFT-1:0] rem2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (ready2) begin
      v2_q <= v1_q && is_eval1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready2 && v1_q && is_eval1) begin
      flags2_q <= flags1;
      last2_q  <= last1;
      rem2_q   <= rem1;
    end
  end

  logic [ACT_W-1:0]     y1_sel;
  logic signed [ACT_W:0] diff2;
  logic signed [PW-1:0] prod2;

  always_comb begin
    // the last sample interpolates toward the upper saturation value
    y1_sel = last2_q ? activ_max_q : y1_rd;
    diff2  = $signed({1'b0, y1_sel}) - $signed({1'b0, y0_rd});
    prod2  = diff2 * $signed({1'b0, rem2_q});
  end

  // stage 3: round the product, add base sample, mirror and clamp
  sli_flags_t           flags3_q;
  logic [ACT_W-1:0]     y0_3_q;
  logic signed [PW-1:0] prod3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (ready3) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready3 && v2_q) begin
      flags3_q <= flags2_q;
      y0_3_q   <= y0_rd;
      prod3_q  <= prod2;
    end
  end

  logic signed [PW:0]   sum3, sum_sh;
  logic signed [FW-1:0] q3, f3, r3;
  logic [ACT_W-1:0]     act3;

  always_comb begin
    sum3   = (PW + 1)'(prod3_q) + HALF_P;
    sum_sh = sum3 >>> FRACTION_SHIFT;
    q3     = sum_sh[FW-1:0];
    f3     = flags3_q.beyond ? $signed(FW'(activ_max_q))
                             : $signed(FW'(y0_3_q)) + q3;
    r3     = flags3_q.neg ? ONE_F - f3 : f3;
    priority if (flags3_q.sat_max) begin
      act3 = activ_max_q;
    end else if (flags3_q.sat_min) begin
      act3 = activ_min_q;
    end else if (r3[FW-1]) begin
      act3 = '0;
    end else if (r3 > $signed(FW'(ACT_FULL))) begin
      act3 = ACT_FULL;
    end else begin
      act3 = r3[ACT_W-1:0];
    end
  end

  // stage 4: output register
  logic [ACT_W-1:0] act4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (ready4) begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready4 && v3_q) begin
      act4_q <= act3;
    end
  end

  assign out_valid_o  = v4_q;
  assign activation_o = act4_q;

  // a table write leaves the pipeline after the table stage
  a_write_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && ready2 && is_write1) |=> !v2_q)
    else $error("table write entered the result pipeline");

  // an empty pipeline never stalls the input side
  a_empty_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!v1_q && !v2_q && !v3_q && !v4_q) |-> !in_stall_o)
    else $error("input stalled with empty pipeline");

  // an upper saturation reaches the output as the configured value
  a_sat_max_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && ready4 && flags3_q.sat_max && !cfg_valid_i) |=> (activation_o == activ_max_q))
    else $error("upper saturation value lost");

  // a held stage keeps its item while the next one is blocked
  a_stage_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v2_q && !ready3) |=> (v2_q && $stable({flags2_q, last2_q, rem2_q})))
    else $error("product stage lost an item under stall");

endmodule

// ----- tb/sv/sigmoid_lut_interpolator_top_tb.sv -----
// self-checking testbench for the sigmoid table interpolator: predicted activations vs dut
`timescale 1ns / 100ps

module sigmoid_lut_interpolator_top_tb;
  import sli_pkg::*;

  localparam int     LUT       = LUT_ENTRIES_DEF;
  localparam int     FRAC      = FRACTION_SHIFT_DEF;
  localparam longint ONE       = longint'(1) << OUT_FRACTION_DEF;
  localparam longint HALF_STEP = longint'(1) << (FRAC - 1);
  localparam longint REM_MASK  = (longint'(1) << FRAC) - 1;
  localparam longint ACT_LIM   = longint'(ACT_FULL);
  localparam longint TWO_POW30 = longint'(1) << 30;

  typedef struct packed {
    sli_req_e                 kind;
    logic [TIDX_W-1:0]        tidx;
    logic [ACT_W-1:0]         tval;
    logic signed [NET_W-1:0]  net_val;
  } lut_req_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                     in_valid = 1'b0;
  logic                     in_stall_o;
  logic                     req_type = 1'b0;
  logic [TIDX_W-1:0]        table_index = '0;
  logic [ACT_W-1:0]         table_value = '0;
  logic signed [NET_W-1:0]  net_input = '0;
  logic                     out_valid_o;
  logic                     out_stall = 1'b0;
  logic [ACT_W-1:0]         activation_o;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready_o;
  sli_cfg_idx_e             cfg_index = CFG_ROUND_INPUT;
  logic [LIM_W-1:0]         cfg_data = '0;

  // register copies, updated as each write lands
  logic                     cfg_round = 1'b0;
  logic [LIM_W-1:0]         cfg_max = MAX_INPUT_RST;
  logic signed [LIM_W-1:0]  cfg_min = MIN_INPUT_RST;
  logic [ACT_W-1:0]         cfg_amax = ACTIV_MAX_RST;
  logic [ACT_W-1:0]         cfg_amin = ACTIV_MIN_RST;

  logic [ACT_W-1:0]         lut_model [LUT];
  bit                       lut_loaded [LUT];

  lut_req_t                 req_queue [$];
  logic [ACT_W-1:0]         act_expect [$];
  lut_req_t                 held;
  logic [ACT_W-1:0]         exp_act;
  int                       send_idle_pct = 0;
  int                       recv_stall_pct = 0;
  int                       errors = 0;

  sigmoid_lut_interpolator_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall_o),
    .req_type_i    (req_type),
    .table_index_i (table_index),
    .table_value_i (table_value),
    .net_input_i   (net_input),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall),
    .activation_o  (activation_o),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  always #1 clk_i = ~clk_i;

  function automatic longint rounded_net(logic signed [NET_W-1:0] net_val);
    longint x;
    x = longint'(net_val);
    if (cfg_round) x += HALF_STEP;
    return x;
  endfunction

  // table entry an evaluation starts from, -1 when it reads no entry
  function automatic int lut_index(logic signed [NET_W-1:0] net_val);
    longint x;
    longint mag;
    x = rounded_net(net_val);
    if (x >= longint'({1'b0, cfg_max}) || x <= longint'(cfg_min)) return -1;
    mag = (x < 0) ? -x : x;
    if ((mag >>> FRAC) >= LUT) return -1;
    return int'(mag >>> FRAC);
  endfunction

  function automatic logic [ACT_W-1:0] predict_activation(logic signed [NET_W-1:0] net_val);
    longint x, mag, y0, y1, f, r;
    int idx;
    x = rounded_net(net_val);
    if (x >= longint'({1'b0, cfg_max})) return cfg_amax;
    if (x <= longint'(cfg_min)) return cfg_amin;
    mag = (x < 0) ? -x : x;
    if ((mag >>> FRAC) >= LUT) begin
      f = cfg_amax;
    end else begin
      idx = int'(mag >>> FRAC);
      y0 = lut_model[idx];
      y1 = (idx == LUT - 1) ? cfg_amax : lut_model[idx + 1];
      // arithmetic shift floors the signed product plus a half step, rounding it
      f = y0 + (((y1 - y0) * (mag & REM_MASK) + HALF_STEP) >>> FRAC);
    end
    r = (x < 0) ? ONE - f : f;
    if (r < 0) r = 0;
    if (r > ACT_LIM) r = ACT_LIM;
    return ACT_W'(r);
  endfunction

  function automatic void record_beat(lut_req_t req);
    if (req.kind == REQ_WRITE) begin
      if (req.tidx < LUT) lut_model[req.tidx] = req.tval;
    end else begin
      act_expect.push_back(predict_activation(req.net_val));
    end
  endfunction

  // driver: one beat held until accepted
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && !in_stall_o) record_beat(held);
      if (!in_valid || !in_stall_o) begin
        if (req_queue.size() > 0 && $urandom_range(99, 0) >= send_idle_pct) begin
          held = req_queue.pop_front();
          in_valid    <= 1'b1;
          req_type    <= held.kind;
          table_index <= held.tidx;
          table_value <= held.tval;
          net_input   <= held.net_val;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each accepted result with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall) begin
        if (act_expect.size() == 0) begin
          $display("%0t: unexpected activation %0d, nothing expected", $time, activation_o);
          errors++;
        end else begin
          exp_act = act_expect.pop_front();
          if (activation_o !== exp_act) begin
            $display("%0t: activation mismatch, expected %0d, got %0d",
                     $time, exp_act, activation_o);
            errors++;
          end
        end
      end
      out_stall <= ($urandom_range(99, 0) < recv_stall_pct);
    end
  end

  task automatic push_write(int idx, logic [ACT_W-1:0] val);
    lut_req_t req;
    req.kind    = REQ_WRITE;
    req.tidx    = TIDX_W'(idx);
    req.tval    = val;
    req.net_val = $urandom;
    if (idx < LUT) lut_loaded[idx] = 1'b1;
    req_queue.push_back(req);
  endtask

  // loads any neighbor sample the evaluation needs before the evaluation itself
  task automatic push_eval(logic signed [NET_W-1:0] net_val);
    lut_req_t req;
    int idx;
    idx = lut_index(net_val);
    if (idx >= 0) begin
      if (!lut_loaded[idx]) push_write(idx, ACT_W'($urandom_range(32767, 0)));
      if (idx < LUT - 1 && !lut_loaded[idx + 1])
        push_write(idx + 1, ACT_W'($urandom_range(32767, 0)));
    end
    req.kind    = REQ_EVAL;
    req.tidx    = TIDX_W'($urandom);
    req.tval    = ACT_W'($urandom);
    req.net_val = net_val;
    req_queue.push_back(req);
  endtask

  function automatic logic signed [NET_W-1:0] rand_net();
    longint lo, hi, val;
    lo = longint'(cfg_min);
    hi = longint'({1'b0, cfg_max});
    case ($urandom_range(9, 0))
      0: val = longint'($urandom);
      1: val = hi + longint'($urandom_range(8, 0)) - 4;
      2: val = lo + longint'($urandom_range(8, 0)) - 4;
      3: begin
        // near a sample boundary or a half step
        val = (longint'($urandom_range(255, 0)) << FRAC)
              + ($urandom_range(1, 0) ? HALF_STEP : 0) + longint'($urandom_range(6, 0)) - 3;
        if ($urandom_range(1, 0)) val = -val;
      end
      default: val = lo + longint'($urandom_range(32'(hi - lo), 0));
    endcase
    return NET_W'(val);
  endfunction

  task automatic run_random(int n);
    repeat (n) begin
      if ($urandom_range(99, 0) < 15)
        push_write($urandom_range(255, 0), ACT_W'($urandom_range(32767, 0)));
      else
        push_eval(rand_net());
    end
  endtask

  task automatic wait_drained();
    while (req_queue.size() > 0 || in_valid || act_expect.size() > 0) @(posedge clk_i);
    // table writes still in the pipeline give no result
    repeat (8) @(posedge clk_i);
  endtask

  task automatic cfg_write(sli_cfg_idx_e idx, logic [LIM_W-1:0] data);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_ROUND_INPUT: cfg_round = data[0];
      CFG_MAX_INPUT:   cfg_max = data;
      CFG_MIN_INPUT:   cfg_min = data;
      CFG_ACTIV_MAX:   cfg_amax = data[ACT_W-1:0];
      CFG_ACTIV_MIN:   cfg_amin = data[ACT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(logic rnd, longint max_in, longint min_in,
                            logic [ACT_W-1:0] amax, logic [ACT_W-1:0] amin);
    cfg_write(CFG_ROUND_INPUT, LIM_W'(rnd));
    cfg_write(CFG_MAX_INPUT, LIM_W'(max_in));
    cfg_write(CFG_MIN_INPUT, LIM_W'(min_in));
    cfg_write(CFG_ACTIV_MAX, LIM_W'(amax));
    cfg_write(CFG_ACTIV_MIN, LIM_W'(amin));
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings, no idling: extremes and corner cases first
    push_write(0, '0);
    push_write(1, ACT_FULL);
    push_write(254, '0);
    push_write(255, ACT_FULL);
    push_eval(0);
    push_eval(1);
    push_eval(-1);                     // mirrored value exceeds full scale
    push_eval((1 <<< FRAC) - 1);
    push_eval(-(1 <<< FRAC) + 1);
    push_eval(1 <<< (FRAC - 1));
    push_eval(32'sd1069547520);        // last sample, toward activ_max
    push_eval(32'sd1067450368);
    push_eval(32'sd1073741823);
    push_eval(32'sd1073741824);        // exactly at the upper limit
    push_eval(-32'sd1073741824);       // exactly at the lower limit
    push_eval(-32'sd1073741823);
    push_eval(32'sh7fff_ffff);
    push_eval(32'sh8000_0000);
    push_write(128, ACT_W'($urandom_range(32767, 0)));
    push_eval(32'sd536870912);
    run_random(130);
    wait_drained();

    send_idle_pct = 67;
    set_config(1'b1, 500000000, -300000000, 15'd30000, 15'd1000);
    run_random(150);
    wait_drained();

    // narrowest limits, swapped saturation values
    send_idle_pct  = 0;
    recv_stall_pct = 67;
    set_config(1'b0, 1, -1, '0, ACT_FULL);
    run_random(100);
    wait_drained();

    // upper limit past the table: index beyond table reaches activ_max
    send_idle_pct  = 20;
    recv_stall_pct = 20;
    set_config(1'b1, 32'h7fff_ffff, -TWO_POW30, ACT_FULL, '0);
    run_random(75);
    wait_drained();
    run_random(75);
    wait_drained();

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    set_config(1'b0, TWO_POW30, -TWO_POW30, ACT_FULL, '0);
    run_random(150);
    wait_drained();

    send_idle_pct  = 20;
    recv_stall_pct = 20;
    set_config($urandom_range(1, 0), longint'($urandom_range(1073741824, 1)),
               -longint'($urandom_range(1073741824, 1)),
               ACT_W'($urandom_range(32767, 0)), ACT_W'($urandom_range(32767, 0)));
    run_random(150);
    recv_stall_pct = 0;
    wait_drained();
    repeat (20) @(posedge clk_i);

    if (act_expect.size() != 0) begin
      $display("%0t: %0d activations never arrived", $time, act_expect.size());
      errors += act_expect.size();
    end
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #500000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/sli_pkg.sv
sv/sli_table.sv
sv/sigmoid_lut_interpolator_top.sv
tb/sv/sigmoid_lut_interpolator_top_tb.sv
